FILE: rtl/assert_macros.svh
// Assertion macros shared by the lowest common ancestor RTL.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LCA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LCA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define LCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/lca_pkg.sv
// Shared types, step codes and the microcode ROM of the lowest common ancestor block.
// No dependencies; used by lca_seq, lca_dpath and the top level.
`timescale 1ns / 1ps

package lca_pkg;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef logic [3:0] step_t;

  localparam step_t S_IDLE = 4'd0;
  localparam step_t S_QDEP = 4'd1;
  localparam step_t S_QCMP = 4'd2;
  localparam step_t S_LRD  = 4'd3;
  localparam step_t S_LUP  = 4'd4;
  localparam step_t S_QEQ  = 4'd5;
  localparam step_t S_CRD  = 4'd6;
  localparam step_t S_CUP  = 4'd7;
  localparam step_t S_PRD  = 4'd8;
  localparam step_t S_PAR  = 4'd9;
  localparam step_t S_LDEP = 4'd10;
  localparam step_t S_LWD  = 4'd11;
  localparam step_t S_LRDJ = 4'd12;
  localparam step_t S_LWJ  = 4'd13;
  localparam step_t S_LAST = S_LWJ;

  typedef enum logic [1:0] {RD_NONE, RD_DEPTH, RD_JUMP} rd_sel_t;
  typedef enum logic [2:0] {OP_NONE, OP_SWAP, OP_LIFT, OP_CLIMB, OP_WDEP, OP_WJMP} op_t;
  typedef enum logic [2:0] {LV_HOLD, LV_TOP, LV_ZERO, LV_DEC, LV_INC} lvl_op_t;
  typedef enum logic [2:0] {C_NEXT, C_ALWAYS, C_LVL_NZ, C_EQ, C_LOAD_END, C_DISPATCH} cond_t;
  typedef enum logic [1:0] {EM_NONE, EM_A, EM_JA} emit_t;

  typedef struct packed {
    rd_sel_t rd;
    op_t     op;
    lvl_op_t lvl;
    cond_t   cond;
    emit_t   emit;
    step_t   target;
  } uword_t;

  typedef struct packed {
    logic lvl_zero;
    logic a_eq_b;
    logic load_end;
  } dp_stat_t;

  typedef struct packed {
    logic accept;
    logic query;
    logic load_ok;
  } req_t;

  localparam uword_t UW_NOP = '{rd: RD_NONE, op: OP_NONE, lvl: LV_HOLD, cond: C_NEXT,
                                emit: EM_NONE, target: S_IDLE};

  // One control word per step. A taken jump goes to target; otherwise the next step.
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = UW_NOP;
    case (s)
      S_IDLE: w = '{RD_NONE,  OP_NONE,  LV_HOLD, C_DISPATCH, EM_NONE, S_IDLE};
      S_QDEP: w = '{RD_DEPTH, OP_NONE,  LV_HOLD, C_NEXT,     EM_NONE, S_IDLE};
      S_QCMP: w = '{RD_NONE,  OP_SWAP,  LV_TOP,  C_NEXT,     EM_NONE, S_IDLE};
      S_LRD:  w = '{RD_JUMP,  OP_NONE,  LV_HOLD, C_NEXT,     EM_NONE, S_IDLE};
      S_LUP:  w = '{RD_NONE,  OP_LIFT,  LV_DEC,  C_LVL_NZ,   EM_NONE, S_LRD};
      S_QEQ:  w = '{RD_NONE,  OP_NONE,  LV_TOP,  C_EQ,       EM_A,    S_IDLE};
      S_CRD:  w = '{RD_JUMP,  OP_NONE,  LV_HOLD, C_NEXT,     EM_NONE, S_IDLE};
      S_CUP:  w = '{RD_NONE,  OP_CLIMB, LV_DEC,  C_LVL_NZ,   EM_NONE, S_CRD};
      S_PRD:  w = '{RD_JUMP,  OP_NONE,  LV_HOLD, C_NEXT,     EM_NONE, S_IDLE};
      S_PAR:  w = '{RD_NONE,  OP_NONE,  LV_HOLD, C_ALWAYS,   EM_JA,   S_IDLE};
      S_LDEP: w = '{RD_DEPTH, OP_NONE,  LV_ZERO, C_NEXT,     EM_NONE, S_IDLE};
      S_LWD:  w = '{RD_NONE,  OP_WDEP,  LV_HOLD, C_NEXT,     EM_NONE, S_IDLE};
      S_LRDJ: w = '{RD_JUMP,  OP_NONE,  LV_HOLD, C_LOAD_END, EM_NONE, S_IDLE};
      S_LWJ:  w = '{RD_NONE,  OP_WJMP,  LV_INC,  C_ALWAYS,   EM_NONE, S_LRDJ};
      default: w = '{RD_NONE, OP_NONE,  LV_HOLD, C_ALWAYS,   EM_NONE, S_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/lca_seq.sv
// Microcode sequencer: step counter, ROM lookup from lca_pkg and jump resolution.
// Depends on lca_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lca_seq
  import lca_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  req_t     req,
  input  dp_stat_t stat,
  input  logic     out_free,
  output uword_t   ctrl,
  output logic     idle
);

  step_t  pc_r, pc_nxt;
  uword_t uw;
  logic   taken;
  logic   hold;

  assign uw = ucode(pc_r);

  always_comb begin
    case (uw.cond)
      C_NEXT:     taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_LVL_NZ:   taken = !stat.lvl_zero;
      C_EQ:       taken = stat.a_eq_b;
      C_LOAD_END: taken = stat.load_end;
      default:    taken = 1'b0;
    endcase
  end

  // A step that hands over a result waits here while the output register is still full and out_stall is high.
  assign hold = taken && (uw.emit != EM_NONE) && !out_free;

  always_comb begin
    if (hold) begin
      pc_nxt = pc_r;
    end else if (uw.cond == C_DISPATCH) begin
      if (req.accept && req.query) begin
        pc_nxt = S_QDEP;
      end else if (req.accept && req.load_ok) begin
        pc_nxt = S_LDEP;
      end else begin
        pc_nxt = S_IDLE;
      end
    end else if (taken) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = pc_r + step_t'(1);
    end
  end

  always_comb begin
    if (hold) begin
      ctrl = UW_NOP;
    end else begin
      ctrl = uw;
      ctrl.emit = taken ? uw.emit : EM_NONE;
    end
  end

  assign idle = (pc_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  `LCA_ASSERT_IMP(a_pc_range, clk, rst_n, 1'b1, pc_r <= S_LAST, "step counter left the program")
  `LCA_ASSERT_NEXT(a_hold_pc, clk, rst_n, hold, $stable(pc_r), "step moved while result waits")
  `LCA_ASSERT_NEXT(a_idle_stays, clk, rst_n, idle && !req.accept, idle, "left idle with no item")

endmodule

FILE: rtl/lca_dpath.sv
// Datapath: node and level registers, the depth, valid and jump memories, and the
// clearing pass after reset. Depends on lca_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lca_dpath
  import lca_pkg::*;
#(
  parameter int NODES  = 65536,
  parameter int LEVELS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [15:0] node_a,
  input  logic [15:0] node_b,
  input  uword_t      ctrl,
  output dp_stat_t    stat,
  output logic        clearing,
  output logic [15:0] result
);

  localparam int NODE_SPAN = (NODES > 65536) ? 65536 : NODES;
  localparam int AW        = $clog2(NODE_SPAN);
  localparam int LW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int JW        = AW + LW;
  localparam int NROWS     = 1 << AW;
  localparam int JROWS     = 1 << JW;

  logic              vld_mem [0:NROWS-1];
  logic [15:0]       dep_mem [0:NROWS-1];
  logic [AW-1:0]     jmp_mem [0:JROWS-1];

  logic [AW-1:0]     a_r, a_nxt, b_r, b_nxt;
  logic [LEVELS-1:0] diff_r, diff_nxt;
  logic [LW-1:0]     lvl_r, lvl_nxt, lvl_inc;
  logic [AW:0]       clr_r;

  logic              vq_a_r, vq_b_r;
  logic [15:0]       dq_a_r, dq_b_r;
  logic [AW-1:0]     jq_a_r, jq_b_r;

  logic [15:0]       da, db, dsub;
  logic [AW-1:0]     ja, jb, clamp_a, clamp_b;

  logic              vw_en, vw_data;
  logic [AW-1:0]     vw_addr;
  logic              jw_en;
  logic [JW-1:0]     jw_addr;
  logic [AW-1:0]     jw_data;
  logic              dp_quiet;

  // Nodes at or above NODES read as the sentinel.
  assign clamp_a = (32'(node_a) < NODES) ? node_a[AW-1:0] : '0;
  assign clamp_b = (32'(node_b) < NODES) ? node_b[AW-1:0] : '0;

  // A node that was never loaded reads depth zero and sentinel ancestors.
  assign da = vq_a_r ? dq_a_r : '0;
  assign db = vq_b_r ? dq_b_r : '0;
  assign ja = vq_a_r ? jq_a_r : '0;
  assign jb = vq_b_r ? jq_b_r : '0;

  assign dsub    = (da > db) ? (da - db) : (db - da);
  assign lvl_inc = lvl_r + LW'(1);
  assign clearing = !clr_r[AW];

  assign stat.lvl_zero = (lvl_r == '0);
  assign stat.a_eq_b   = (a_r == b_r);
  assign stat.load_end = (32'(lvl_r) + 32'd1 >= 32'(LEVELS));

  assign result = (ctrl.emit == EM_A) ? 16'(a_r) : 16'(ja);

  assign dp_quiet = (ctrl.op == OP_NONE) && (ctrl.rd == RD_NONE) && !accept;

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    diff_nxt = diff_r;
    if (accept) begin
      a_nxt = clamp_a;
      b_nxt = clamp_b;
    end
    case (ctrl.op)
      OP_SWAP: begin
        // Keep the shallower node in a so that b is the one lifted.
        if (da > db) begin
          a_nxt = b_r;
          b_nxt = a_r;
        end
        diff_nxt = LEVELS'(dsub);
      end
      OP_LIFT: begin
        if (diff_r[lvl_r]) begin
          b_nxt = jb;
        end
      end
      OP_CLIMB: begin
        if (ja != jb) begin
          a_nxt = ja;
          b_nxt = jb;
        end
      end
      OP_WJMP: b_nxt = jb;
      default: ;
    endcase
  end

  always_comb begin
    case (ctrl.lvl)
      LV_TOP:  lvl_nxt = LW'(LEVELS - 1);
      LV_ZERO: lvl_nxt = '0;
      LV_DEC:  lvl_nxt = (lvl_r == '0) ? '0 : lvl_r - LW'(1);
      LV_INC:  lvl_nxt = lvl_inc;
      default: lvl_nxt = lvl_r;
    endcase
  end

  always_comb begin
    vw_en   = 1'b0;
    vw_addr = a_r;
    vw_data = 1'b1;
    jw_en   = 1'b0;
    jw_addr = {a_r, LW'(0)};
    jw_data = b_r;
    if (clearing) begin
      vw_en   = 1'b1;
      vw_addr = clr_r[AW-1:0];
      vw_data = 1'b0;
    end else if (ctrl.op == OP_WDEP) begin
      vw_en = 1'b1;
      jw_en = 1'b1;
    end else if (ctrl.op == OP_WJMP) begin
      jw_en   = 1'b1;
      jw_addr = {a_r, lvl_inc};
      jw_data = jb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      lvl_r <= '0;
    end else begin
      if (clearing) begin
        clr_r <= clr_r + (AW+1)'(1);
      end
      lvl_r <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    diff_r <= diff_nxt;
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd != RD_NONE) begin
      vq_a_r <= vld_mem[a_r];
      vq_b_r <= vld_mem[b_r];
    end
    if (vw_en) begin
      vld_mem[vw_addr] <= vw_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd == RD_DEPTH) begin
      dq_a_r <= dep_mem[a_r];
      dq_b_r <= dep_mem[b_r];
    end
    if (ctrl.op == OP_WDEP && !clearing) begin
      dep_mem[a_r] <= db + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd == RD_JUMP) begin
      jq_a_r <= jmp_mem[{a_r, lvl_r}];
      jq_b_r <= jmp_mem[{b_r, lvl_r}];
    end
    if (jw_en) begin
      jmp_mem[jw_addr] <= jw_data;
    end
  end

  `LCA_ASSERT_NEXT(a_clear_once, clk, rst_n, !clearing, !clearing, "clearing pass restarted")
  `LCA_ASSERT_IMP(a_quiet_clear, clk, rst_n, clearing, dp_quiet, "datapath busy while clearing")
  `LCA_ASSERT_IMP(a_lvl_range, clk, rst_n, 1'b1, 32'(lvl_r) < 32'(LEVELS), "level out of range")

endmodule

FILE: rtl/lowest_common_ancestor_lifting.sv
// Top level of the binary lifting lowest common ancestor block: handshakes and the
// output register. Depends on lca_pkg, lca_seq and lca_dpath.
`timescale 1ns / 1ps
//
// Input channel (in_valid / in_stall): an item with in_kind = 0 loads node in_node_a
// with parent in_node_b; parents go in before children, node 0 is the sentinel above
// every root. An item with in_kind = 1 asks for the lowest common ancestor of
// in_node_a and in_node_b. Output channel (out_valid / out_stall) carries one
// out_common_ancestor per query and nothing for a load.
// One item is worked at a time by a microcoded sequencer over single-word memories,
// so every jump-table lookup is a read step and a use step.
// A load of node 0 or of a node at or above NODES is taken and dropped. A query whose
// nodes are one the ancestor of the other ends after its lift steps, without the climb,
// and each result shows on out_valid in the cycle after the step that hands it over.
// After reset a clearing pass marks every node unloaded, one node per cycle, over all
// 2**clog2(min(NODES, 65536)) rows of the valid memory; in_stall stays high through it.
// A result waits in the output register while out_stall is high; the next item is
// still taken, and a following query holds at its last step until the register frees.

module lowest_common_ancestor_lifting
  import lca_pkg::*;
#(
  parameter int NODES  = 65536,
  parameter int LEVELS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [15:0] in_node_a,
  input  logic [15:0] in_node_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_common_ancestor
);

  req_t        req;
  dp_stat_t    stat;
  uword_t      ctrl;
  logic        idle, clearing, accept, out_free;
  logic [15:0] result;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_ca_r;

  assign in_stall = !idle || clearing;
  assign accept   = in_valid && !in_stall;

  assign req.accept  = accept;
  assign req.query   = (in_kind == KIND_QUERY);
  assign req.load_ok = (in_node_a != 16'd0) && (32'(in_node_a) < NODES);

  assign out_free = !out_valid_r || !out_stall;

  lca_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .stat     (stat),
    .out_free (out_free),
    .ctrl     (ctrl),
    .idle     (idle)
  );

  lca_dpath #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .node_a   (in_node_a),
    .node_b   (in_node_b),
    .ctrl     (ctrl),
    .stat     (stat),
    .clearing (clearing),
    .result   (result)
  );

  always_comb begin
    if (ctrl.emit != EM_NONE) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit != EM_NONE) begin
      out_ca_r <= result;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_common_ancestor = out_ca_r;

endmodule

FILE: tb/lca_answer_checker.sv
// Checker for the lowest common ancestor block: watches both channels, keeps its own
// depth and jump tables, predicts each query's answer and compares it on the result channel.
// Depends on lca_pkg for the item kind code.
`timescale 1ns / 1ps

module lca_answer_checker
  import lca_pkg::*;
#(
  parameter int NODES  = 65536,
  parameter int LEVELS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_kind,
  input  logic [15:0] in_node_a,
  input  logic [15:0] in_node_b,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_common_ancestor,
  output int unsigned pending,
  output int unsigned mismatches
);

  // Ancestor at level j of node n lives at n*LEVELS + j. Zero means the sentinel.
  bit [15:0]   hop_tab [NODES*LEVELS];
  bit [15:0]   depth_of [NODES];
  bit [15:0]   ancestor_q [$];
  int unsigned fails = 0;

  function automatic int unsigned as_node(input logic [15:0] v);
    return (v < NODES) ? int'(v) : 0;
  endfunction

  function automatic int unsigned hop_of(input int unsigned n, input int unsigned lvl);
    if (n >= NODES || lvl >= LEVELS) begin
      return 0;
    end
    return 32'(hop_tab[n*LEVELS + lvl]);
  endfunction

  function automatic void attach_node(input int unsigned n, input int unsigned parent);
    int unsigned row;
    int unsigned j;
    row = n * LEVELS;
    depth_of[n] = depth_of[parent] + 16'd1;
    hop_tab[row] = parent[15:0];
    for (j = 1; j < LEVELS; j++) begin
      hop_tab[row + j] = 16'(hop_of(32'(hop_tab[row + j - 1]), j - 1));
    end
  endfunction

  function automatic bit [15:0] shared_ancestor(input int unsigned a, input int unsigned b);
    int unsigned swap_tmp;
    int unsigned gap;
    int unsigned pa;
    int unsigned pb;
    int          i;
    if (depth_of[a] > depth_of[b]) begin
      swap_tmp = a;
      a = b;
      b = swap_tmp;
    end
    gap = 32'(depth_of[b]) - 32'(depth_of[a]);
    // Only the low LEVELS bits of the depth gap take part in the lift.
    for (i = LEVELS - 1; i >= 0; i--) begin
      if (gap[i]) begin
        b = hop_of(b, i);
      end
    end
    if (a == b) begin
      return a[15:0];
    end
    for (i = LEVELS - 1; i >= 0; i--) begin
      pa = hop_of(a, i);
      pb = hop_of(b, i);
      if (pa != pb) begin
        a = pa;
        b = pb;
      end
    end
    return 16'(hop_of(a, 0));
  endfunction

  always @(posedge clk) begin
    bit [15:0] want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (ancestor_q.size() == 0) begin
          $error("common_ancestor: no answer expected, actual %0d", out_common_ancestor);
          fails++;
        end else begin
          want = ancestor_q.pop_front();
          if (out_common_ancestor !== want) begin
            $error("common_ancestor mismatch: expected %0d, actual %0d", want,
                   out_common_ancestor);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_kind == KIND_QUERY) begin
          ancestor_q = {ancestor_q,
                        shared_ancestor(as_node(in_node_a), as_node(in_node_b))};
        end else if (in_node_a != 16'd0 && in_node_a < NODES) begin
          attach_node(32'(in_node_a), as_node(in_node_b));
        end
      end
      pending    <= ancestor_q.size();
      mismatches <= fails;
    end
  end

endmodule

FILE: tb/tb_lowest_common_ancestor_lifting.sv
// Testbench top for lowest_common_ancestor_lifting: clock, reset, tree-building and
// query stimulus, receiver stalls, watchdog and verdict. Depends on lca_pkg, the block
// and lca_answer_checker.
`timescale 1ns / 1ps

module tb_lowest_common_ancestor_lifting
  import lca_pkg::*;
();

  localparam int          NODES       = 65536;
  localparam int          LEVELS      = 16;
  localparam int          ITEMS       = 2000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          TAIL_CYCLES = 120;
  // The clearing pass after reset alone keeps the input stalled while all 65536 nodes are cleared.
  localparam int unsigned QUIET_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic [15:0] in_node_a;
  logic [15:0] in_node_b;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_common_ancestor;
  int unsigned pending;
  int unsigned mismatches;
  bit          calm     = 1'b0;
  bit          hold_req = 1'b0;

  lowest_common_ancestor_lifting #(
    .NODES (NODES),
    .LEVELS(LEVELS)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_node_a          (in_node_a),
    .in_node_b          (in_node_b),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_common_ancestor(out_common_ancestor)
  );

  lca_answer_checker #(
    .NODES (NODES),
    .LEVELS(LEVELS)
  ) i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_node_a          (in_node_a),
    .in_node_b          (in_node_b),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_common_ancestor(out_common_ancestor),
    .pending            (pending),
    .mismatches         (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offers one item and holds it until taken, then sometimes leaves a gap.
  task automatic offer(input logic kind, input logic [15:0] a, input logic [15:0] b);
    in_valid  <= 1'b1;
    in_kind   <= kind;
    in_node_a <= a;
    in_node_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!calm && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
    end
  endtask

  // Stops sending until every expected answer has come back.
  task automatic drain_answers();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, one long hold-off on request, none while calm.
  initial begin
    bit held;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 24);
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("lowest_common_ancestor_lifting test failed");
    $finish;
  end

  initial begin
    logic [15:0] tree_nodes [$];
    logic [15:0] newest;
    logic [15:0] pick;
    logic [15:0] parent;
    logic [15:0] qa;
    logic [15:0] qb;
    int unsigned counted;
    int unsigned next_tree;
    int unsigned tree_idx;
    int unsigned chain;
    int unsigned r;
    int unsigned r2;
    int unsigned n;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_kind   = KIND_LOAD;
    in_node_a = 16'd0;
    in_node_b = 16'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Sentinel and never-loaded nodes before anything is built.
    offer(KIND_QUERY, 16'd0, 16'd0);
    offer(KIND_QUERY, 16'hFFFF, 16'h0001);
    // Loading the sentinel is ignored.
    offer(KIND_LOAD, 16'd0, 16'd5);
    // A small tree with the extreme node numbers.
    offer(KIND_LOAD, 16'hFFFF, 16'd0);
    offer(KIND_LOAD, 16'h0001, 16'hFFFF);
    offer(KIND_LOAD, 16'h8000, 16'h0001);
    offer(KIND_LOAD, 16'h7FFF, 16'hFFFF);
    offer(KIND_QUERY, 16'h8000, 16'h7FFF);
    offer(KIND_QUERY, 16'h8000, 16'hFFFF);
    offer(KIND_QUERY, 16'hFFFF, 16'h8000);
    offer(KIND_QUERY, 16'h8000, 16'h8000);
    offer(KIND_QUERY, 16'h8000, 16'd0);
    offer(KIND_QUERY, 16'h1234, 16'h8000);
    // Parent never loaded, and a node that is its own parent.
    offer(KIND_LOAD, 16'h00F0, 16'h4321);
    offer(KIND_QUERY, 16'h00F0, 16'h7FFF);
    offer(KIND_LOAD, 16'h0F0F, 16'h0F0F);
    offer(KIND_QUERY, 16'h0F0F, 16'h8000);
    // Reloads: a node moves, then the root hangs below its own descendant.
    offer(KIND_LOAD, 16'h0001, 16'h7FFF);
    offer(KIND_QUERY, 16'h8000, 16'h0001);
    offer(KIND_LOAD, 16'hFFFF, 16'h8000);
    offer(KIND_QUERY, 16'h7FFF, 16'h0001);
    offer(KIND_QUERY, 16'hFFFF, 16'h00F0);

    counted   = 0;
    next_tree = 0;
    tree_idx  = 0;
    newest    = 16'd0;
    while (counted < ITEMS) begin
      if (counted >= next_tree) begin
        case (tree_idx)
          2: hold_req <= 1'b1;
          3: drain_answers();
          4: calm <= 1'b1;
          5: calm <= 1'b0;
          default: ;
        endcase
        // Each tree starts with a chain; the first one is long enough for deep lifts.
        tree_nodes.delete();
        newest = 16'd0;
        chain  = (tree_idx == 0) ? 520 : $urandom_range(4, 40);
        for (n = 0; n < chain; n++) begin
          pick = 16'($urandom_range(1, 65535));
          offer(KIND_LOAD, pick, newest);
          tree_nodes = {tree_nodes, pick};
          newest = pick;
          counted++;
        end
        tree_idx++;
        next_tree = counted + $urandom_range(120, 250);
      end

      r = $urandom_range(0, 99);
      if (r < 45) begin
        r = $urandom_range(0, 99);
        if (r < 85) begin
          pick = 16'($urandom_range(1, 65535));
        end else if (r < 94) begin
          pick = tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
        end else if (r < 97) begin
          pick = 16'd0;
        end else begin
          pick = 16'($urandom_range(0, 65535));
        end
        r2 = $urandom_range(0, 99);
        if (r2 < 3) begin
          parent = pick;
        end else if (r2 < 50) begin
          parent = newest;
        end else if (r2 < 88) begin
          parent = tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
        end else if (r2 < 94) begin
          parent = 16'd0;
        end else begin
          parent = 16'($urandom_range(0, 65535));
        end
        offer(KIND_LOAD, pick, parent);
        if (pick != 16'd0) begin
          counted++;
          if (r2 >= 3) begin
            tree_nodes = {tree_nodes, pick};
            newest = pick;
          end
        end
      end else begin
        qa = tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
        qb = tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
        r  = $urandom_range(0, 99);
        if (r < 8) begin
          qb = qa;
        end else if (r < 15) begin
          qb = 16'($urandom_range(0, 65535));
        end else if (r < 20) begin
          qa = 16'd0;
        end else if (r < 25) begin
          qa = 16'($urandom_range(0, 65535));
          qb = 16'($urandom_range(0, 65535));
        end
        offer(KIND_QUERY, qa, qb);
        counted++;
      end
    end

    drain_answers();
    // A trailing load may still be in progress; give it time and catch stray answers.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("lowest_common_ancestor_lifting test passed");
    end else begin
      $display("lowest_common_ancestor_lifting test failed");
    end
    $finish;
  end

endmodule
